// ===== hdl/ubxnav_pkg.sv =====
// Shared constants, types and helpers of the UBX NAV reply parser.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package ubxnav_pkg;

	// Frame constants of the UBX protocol.
	localparam logic [7:0] Sync1     = 8'hB5;
	localparam logic [7:0] Sync2     = 8'h62;
	localparam logic [7:0] ClassNav  = 8'h01;
	localparam logic [7:0] IdPosllh  = 8'h02;
	localparam logic [7:0] IdTimeutc = 8'h21;
	localparam logic [7:0] IdStatus  = 8'h06;
	localparam logic [7:0] FixOkMask = 8'h01;

	// Codes of the message_kind register.
	localparam logic [1:0] KindPosllh  = 2'd0;
	localparam logic [1:0] KindTimeutc = 2'd1;
	localparam logic [1:0] KindStatus  = 2'd2;
	localparam logic [1:0] KindUnused  = 2'd3;

	// Frame lengths in bytes and the byte position that marks a finished frame.
	localparam logic [5:0] LenPosllh  = 6'd36;
	localparam logic [5:0] LenTimeutc = 6'd28;
	localparam logic [5:0] LenStatus  = 6'd60;
	localparam logic [5:0] IdxIdle    = 6'd63;

	// One result of the parser.
	typedef struct packed {
		logic               sync_error;
		logic               header_error;
		logic               checksum_error;
		logic signed [31:0] longitude;
		logic signed [31:0] latitude;
		logic signed [31:0] altitude;
		logic [7:0]         hour;
		logic [7:0]         minute;
		logic [7:0]         second;
		logic [7:0]         fix_type;
		logic [7:0]         satellites;
	} result_t;

	// Control of the checksum unit for one accepted byte.
	typedef struct packed {
		logic en;     // a byte is accepted this cycle
		logic clear;  // the byte starts a new frame
		logic add;    // the byte lies inside the checksum range
	} fletcher_ctl_t;

	function automatic logic [5:0] frame_len(input logic [1:0] kind);
		logic [5:0] len;
		unique case (kind)
			KindPosllh:  len = LenPosllh;
			KindTimeutc: len = LenTimeutc;
			default:     len = LenStatus;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/ubxnav_if.sv =====
// Handshake channels of the UBX NAV reply parser: received bytes in, results out.
// Depends on ubxnav_pkg for the result type.
`default_nettype none

interface ubxnav_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;
	logic       frame_start;

	modport source (output valid, output data, output frame_start, input ready);
	modport sink   (input valid, input data, input frame_start, output ready);
endinterface

interface ubxnav_result_if;
	logic                 valid;
	logic                 ready;
	ubxnav_pkg::result_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hdl/ubxnav_fletcher.sv =====
// Running 8-bit Fletcher sums over the class, id, length and payload bytes.
// Depends on ubxnav_pkg for the control struct.
`default_nettype none

module ubxnav_fletcher (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire ubxnav_pkg::fletcher_ctl_t ctl,
	input  wire logic [7:0]                data,
	output logic [7:0]                     sum_a,
	output logic [7:0]                     sum_b
);
	import ubxnav_pkg::*;

	logic [7:0] sum_a_q;
	logic [7:0] sum_b_q;
	logic [7:0] sum_a_nxt;
	logic [7:0] sum_b_nxt;

	// Sums as seen by the current byte: a frame start clears them first.
	assign sum_a = ctl.clear ? 8'd0 : sum_a_q;
	assign sum_b = ctl.clear ? 8'd0 : sum_b_q;

	always_comb begin
		sum_a_nxt = sum_a;
		sum_b_nxt = sum_b;
		if (ctl.add) begin
			sum_a_nxt = sum_a + data;
			sum_b_nxt = sum_b + sum_a_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_a_q <= 8'd0;
			sum_b_q <= 8'd0;
		end else if (ctl.en) begin
			sum_a_q <= sum_a_nxt;
			sum_b_q <= sum_b_nxt;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/ubx_nav_reply_parser_unit.sv =====
// Top level of the UBX NAV reply parser: frame tracking, field capture, result register.
// Depends on ubxnav_pkg, the channel interfaces in ubxnav_if and ubxnav_fletcher.
//
// Usage
//   The req channel carries one received byte per request, with frame_start
//   high on the first byte of a reply frame. The rsp channel carries one
//   result per complete frame: the sync, header and checksum error flags and
//   the fields of the message that message_kind selects (other fields zero).
//   message_kind is written through cfg_wr_en / cfg_wr_data; the user must
//   write it only while the block is idle, which is not enforced. 0 selects
//   NAV-POSLLH (36 bytes), 1 NAV-TIMEUTC (28 bytes), 2 NAV-STATUS (60 bytes).
//   Each byte is handled in the cycle it is accepted, so one request can be
//   taken every clock cycle unless a held result blocks it. A frame's result
//   appears on rsp in the cycle after its last byte is accepted.
//   The result sits in a single output register. While it waits for the
//   receiver, the next byte is still taken in the same cycle that the result
//   is taken; only a result that is held and not taken stops req.
//   After reset the register selects NAV-POSLLH, all sums, flags and captured
//   fields are zero, and a byte without frame_start counts as the first byte
//   of a frame. Bytes past the end of a frame are dropped until frame_start.
`default_nettype none

module ubx_nav_reply_parser_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_wr_data,
	ubxnav_byte_if.sink      req,
	ubxnav_result_if.source  rsp
);
	import ubxnav_pkg::*;

	// Configuration and frame state.
	logic [1:0]  kind_q;
	logic [5:0]  idx_q;
	logic        sync_bad_q;
	logic        header_bad_q;
	logic [7:0]  rcv_sum_a_q;

	// Captured fields; they survive across frames and are overwritten only
	// at their byte positions.
	logic [31:0] lon_q;
	logic [31:0] lat_q;
	logic [31:0] alt_q;
	logic [7:0]  hour_q;
	logic [7:0]  minute_q;
	logic [7:0]  second_q;
	logic [7:0]  gps_fix_q;
	logic [7:0]  fix_flags_q;
	logic [7:0]  sats_q;

	// Result register.
	logic        rsp_valid_q;
	result_t     rsp_q;

	// Per-byte decode.
	logic        accept;
	logic [7:0]  b;
	logic [5:0]  len;
	logic [5:0]  idx;
	logic [6:0]  idx_p1;
	logic [6:0]  idx_p2;
	logic        sync_bad;
	logic        header_bad;
	logic        active;
	logic        last;
	logic        id_ok;
	logic [1:0]  lane;
	logic [4:0]  lane_bit;
	logic [7:0]  sum_a;
	logic [7:0]  sum_b;
	fletcher_ctl_t fl_ctl;
	result_t     result;

	assign accept = req.valid && req.ready;
	assign b      = req.data;

	// Ready whenever the result register is free or is being emptied.
	assign req.ready   = !rsp_valid_q || rsp.ready;
	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	// A frame start resets the position and flags before the byte is judged.
	assign len        = frame_len(kind_q);
	assign idx        = req.frame_start ? 6'd0 : idx_q;
	assign sync_bad   = req.frame_start ? 1'b0 : sync_bad_q;
	assign header_bad = req.frame_start ? 1'b0 : header_bad_q;
	assign idx_p1     = {1'b0, idx} + 7'd1;
	assign idx_p2     = {1'b0, idx} + 7'd2;
	assign active     = idx < len;
	assign last       = active && (idx_p1 == {1'b0, len});

	// All multi-byte fields start two below a multiple of four, so the byte
	// lane inside the word is the low two position bits minus two.
	assign lane     = idx[1:0] - 2'd2;
	assign lane_bit = {lane, 3'b000};

	always_comb begin
		unique case (kind_q)
			KindPosllh:  id_ok = (b == IdPosllh);
			KindTimeutc: id_ok = (b == IdTimeutc);
			KindStatus:  id_ok = (b == IdStatus);
			KindUnused:  id_ok = 1'b0;
			default:     id_ok = 1'b0;
		endcase
	end

	// The checksum covers class byte through the last payload byte.
	assign fl_ctl.en    = accept;
	assign fl_ctl.clear = req.frame_start;
	assign fl_ctl.add   = active && (idx >= 6'd2) && (idx_p2 < {1'b0, len});

	ubxnav_fletcher u_fletcher (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (fl_ctl),
		.data   (b),
		.sum_a  (sum_a),
		.sum_b  (sum_b)
	);

	// Result of a frame that ends with this byte. The trailing checksum bytes
	// are compared against the sums over everything before them.
	always_comb begin
		result                = '0;
		result.sync_error     = sync_bad;
		result.header_error   = header_bad;
		result.checksum_error = (rcv_sum_a_q != sum_a) || (b != sum_b);
		unique case (kind_q)
			KindPosllh: begin
				result.longitude = lon_q;
				result.latitude  = lat_q;
				result.altitude  = alt_q;
			end
			KindTimeutc: begin
				result.hour   = hour_q;
				result.minute = minute_q;
				result.second = second_q;
			end
			KindStatus: begin
				result.fix_type   = ((fix_flags_q & FixOkMask) != 8'd0) ? gps_fix_q : 8'd0;
				result.satellites = sats_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KindPosllh;
		end else if (cfg_wr_en) begin
			kind_q <= cfg_wr_data;
		end
	end

	// Frame position, error flags and the received first checksum byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= 6'd0;
			sync_bad_q   <= 1'b0;
			header_bad_q <= 1'b0;
			rcv_sum_a_q  <= 8'd0;
		end else if (accept) begin
			idx_q        <= idx;
			sync_bad_q   <= sync_bad;
			header_bad_q <= header_bad;
			if (active) begin
				idx_q <= last ? IdxIdle : idx_p1[5:0];
				if ((idx == 6'd0 && b != Sync1) || (idx == 6'd1 && b != Sync2)) begin
					sync_bad_q <= 1'b1;
				end
				if ((idx == 6'd2 && b != ClassNav) || (idx == 6'd3 && !id_ok)) begin
					header_bad_q <= 1'b1;
				end
				if (idx_p2 == {1'b0, len}) begin
					rcv_sum_a_q <= b;
				end
			end
		end
	end

	// Field capture at the byte positions of the selected message.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lon_q       <= '0;
			lat_q       <= '0;
			alt_q       <= '0;
			hour_q      <= '0;
			minute_q    <= '0;
			second_q    <= '0;
			gps_fix_q   <= '0;
			fix_flags_q <= '0;
			sats_q      <= '0;
		end else if (accept && active) begin
			unique case (kind_q)
				KindPosllh: begin
					if (idx >= 6'd10 && idx <= 6'd13) lon_q[lane_bit +: 8] <= b;
					if (idx >= 6'd14 && idx <= 6'd17) lat_q[lane_bit +: 8] <= b;
					if (idx >= 6'd22 && idx <= 6'd25) alt_q[lane_bit +: 8] <= b;
				end
				KindTimeutc: begin
					if (idx == 6'd22) hour_q   <= b;
					if (idx == 6'd23) minute_q <= b;
					if (idx == 6'd24) second_q <= b;
				end
				KindStatus: begin
					if (idx == 6'd16) gps_fix_q   <= b;
					if (idx == 6'd17) fix_flags_q <= b;
					if (idx == 6'd53) sats_q      <= b;
				end
				default: begin
				end
			endcase
		end
	end

	// Output register: loaded on the last byte of a frame, emptied when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept && last) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last) begin
			rsp_q <= result;
		end
	end

	// The frame position is either inside the longest frame or parked.
	assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q <= LenStatus) || (idx_q == IdxIdle))
	else $error("frame position out of range");

	// A new result only ever follows an accepted byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(accept))
	else $error("result appeared without an accepted byte");

	// The last byte of a frame parks the position until the next frame start.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last) |=> (idx_q == IdxIdle))
	else $error("frame position not parked after the last byte");

endmodule

`default_nettype wire
